### design/isim_pkg.sv
// Shared types, states and a helper function for the interval set insert-and-merge block.
package isim_pkg;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] limit;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_RDL,
		S_RDR,
		S_DEC,
		S_MOVE,
		S_WR
	} state_t;

	function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

### design/isim_ram.sv
// Interval table storage: one write port, one read port with registered read data.
module isim_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output isim_pkg::entry_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  isim_pkg::entry_t wr_data
);
	import isim_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/interval_set_insert_merge_top.sv
// Top level of the sorted interval set with insert-and-merge.
//
// A request is taken when start is high and busy is low; exactly one result follows, shown for
// one cycle with done high, and the receiver cannot stall it. The table lives in one
// single-port-read, single-port-write memory with registered read data, and every step goes
// through it: each binary search probe is a read state (S_SRCH) and a compare state (S_CMP), the
// two neighbour reads pass through S_RDL and S_RDR before the decision in S_DEC, and an insert or
// a removal moves every entry above the slot by one place at one entry per cycle, then drains the
// last pending move write, followed by the final write. Busy falls in the cycle done is shown. No
// clearing pass is needed after reset: only entries below the count are ever used.
module interval_set_insert_merge_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	output logic        done,
	output logic [31:0] stored_start,
	output logic [31:0] stored_end,
	output logic [8:0]  entry_count,
	output logic        dropped
);
	import isim_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_nxt;

	logic [31:0]   key_q, end_q;
	logic [CW-1:0] count_q, lo_q, hi_q, mid_q, idx_q, mv_left_q;
	logic [AW-1:0] mv_src_q, pend_dst_q, wr_addr_q;
	logic          mv_up_q, pend_q, drop_q;
	entry_t        left_q, wr_data_q;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        rd_data, wr_data;

	logic [CW-1:0] mid, cnt_up, cnt_dn;
	logic          has_l, has_r, left_hit, right_hit, full, move_go;
	logic [31:0]   merged_end;

	isim_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign busy = (state_q != S_IDLE);

	// decision terms
	always_comb begin
		mid        = lo_q + ((hi_q - lo_q) >> 1);
		has_l      = (idx_q != '0);
		has_r      = (idx_q < count_q);
		left_hit   = has_l && (left_q.limit >= key_q);
		right_hit  = has_r && (rd_data.base <= end_q);
		full       = (count_q == CW'(TABLE_DEPTH));
		cnt_up     = count_q - idx_q;
		cnt_dn     = count_q - idx_q - CW'(1);
		move_go    = left_hit ? (right_hit && (cnt_dn != '0))
		                      : (!right_hit && !full && (cnt_up != '0));
		merged_end = max32(left_q.limit, end_q);
		if (right_hit) begin
			merged_end = max32(merged_end, rd_data.limit);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_nxt = S_SRCH;
			S_SRCH: state_nxt = (lo_q < hi_q) ? S_CMP : S_RDL;
			S_CMP:  state_nxt = (rd_data.base == key_q) ? S_WR : S_SRCH;
			S_RDL:  state_nxt = S_RDR;
			S_RDR:  state_nxt = S_DEC;
			S_DEC:  state_nxt = move_go ? S_MOVE : S_WR;
			S_MOVE: if (mv_left_q == '0 && pend_q) state_nxt = S_WR;
			S_WR:   state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = wr_addr_q;
		wr_data = wr_data_q;
		unique case (state_q)
			S_SRCH: begin
				rd_en   = (lo_q < hi_q);
				rd_addr = mid[AW-1:0];
			end
			S_RDL: begin
				rd_en   = 1'b1;
				rd_addr = AW'(idx_q - CW'(1));
			end
			S_RDR: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			S_MOVE: begin
				rd_en   = (mv_left_q != '0);
				rd_addr = mv_src_q;
				wr_en   = pend_q;
				wr_addr = pend_dst_q;
				wr_data = rd_data;
			end
			S_WR: wr_en = !drop_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done    <= (state_q == S_WR);
			pend_q  <= (state_q == S_MOVE) && (mv_left_q != '0);
			if (state_q == S_DEC && !left_hit && !right_hit && !full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DEC && left_hit && right_hit) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q  <= range_start;
				end_q  <= range_end;
				lo_q   <= '0;
				hi_q   <= count_q;
				drop_q <= 1'b0;
			end
			S_SRCH: begin
				mid_q <= mid;
				idx_q <= lo_q;
			end
			S_CMP: begin
				if (rd_data.base == key_q) begin
					wr_addr_q <= mid_q[AW-1:0];
					wr_data_q <= '{base: rd_data.base, limit: max32(rd_data.limit, end_q)};
				end else if (rd_data.base < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_RDR: left_q <= rd_data;
			S_DEC: begin
				if (left_hit) begin
					wr_addr_q <= AW'(idx_q - CW'(1));
					wr_data_q <= '{base: left_q.base, limit: merged_end};
					mv_up_q   <= 1'b0;
					mv_src_q  <= AW'(idx_q + CW'(1));
					mv_left_q <= cnt_dn;
				end else if (right_hit) begin
					wr_addr_q <= idx_q[AW-1:0];
					wr_data_q <= '{base: key_q, limit: max32(rd_data.limit, end_q)};
				end else if (full) begin
					drop_q <= 1'b1;
				end else begin
					wr_addr_q <= idx_q[AW-1:0];
					wr_data_q <= '{base: key_q, limit: end_q};
					mv_up_q   <= 1'b1;
					mv_src_q  <= AW'(count_q - CW'(1));
					mv_left_q <= cnt_up;
				end
			end
			S_MOVE: begin
				if (mv_left_q != '0) begin
					mv_left_q  <= mv_left_q - CW'(1);
					mv_src_q   <= mv_up_q ? mv_src_q - AW'(1) : mv_src_q + AW'(1);
					pend_dst_q <= mv_up_q ? mv_src_q + AW'(1) : mv_src_q - AW'(1);
				end
			end
			S_WR: begin
				stored_start <= drop_q ? '0 : wr_data_q.base;
				stored_end   <= drop_q ? '0 : wr_data_q.limit;
				entry_count  <= 9'(count_q);
				dropped      <= drop_q;
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("result shown while a request is still in progress");

	a_no_write_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH || state_q == S_CMP || state_q == S_RDL || state_q == S_RDR) |-> !wr_en)
		else $error("table written during lookup");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (count_q == CW'(TABLE_DEPTH)))
		else $error("request dropped with room in the table");

endmodule
